/* hdl/psvm_pkg.sv */
package psvm_pkg;

    localparam int VOICES_DEF       = 16;
    localparam int SAMPLE_RATE_DEF  = 44100;
    localparam int PHASE_BITS_DEF   = 32;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int NOTES     = 128;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int CMD_W     = 2;
    localparam int SAMPLE_W  = 16;
    localparam int AMP       = 2047;
    localparam int SINE_W    = $clog2(AMP + 1) + 1;
    localparam int Q_FRAC    = 30;
    localparam int SEMIS     = 12;
    localparam int REF_NOTE  = 69;
    localparam int OCT_BIAS  = (REF_NOTE + SEMIS - 1) / SEMIS;
    localparam int NOTE_BIAS = OCT_BIAS * SEMIS - REF_NOTE;
    localparam int PIPE_DRAIN = 3;

    localparam logic [63:0] REF_FREQ = 64'd440;
    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] ONE_Q30  = 64'd1073741824;
    localparam logic [63:0] MAG_RND  = 64'd4096;

    localparam logic [63:0] SEMI_Q30 [SEMIS] = '{
        64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
        64'd1352829927, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };

    localparam logic [63:0] TAYLOR_DEN [6] = '{
        64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_ON,
        OP_OFF,
        OP_TICK,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic out_free;
    } t_dp_sts;

endpackage

/* hdl/psvm_stream_if.sv */
interface psvm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/polyphonic_sine_voice_mixer.sv */
// A tick item shows its sample after the walk over all voice slots and the pipeline drain.
// Items are taken one at a time: a new item is accepted only once the controller is idle,
//   after the walk over the voice slots; a tick also waits for room in the output register.
// A finished sample waits in the output register while the next item is taken.
// Reset: synchronous, active low; silences all voices and clears controller and output.
module polyphonic_sine_voice_mixer #(
    parameter int VOICES       = psvm_pkg::VOICES_DEF,
    parameter int SAMPLE_RATE  = psvm_pkg::SAMPLE_RATE_DEF,
    parameter int PHASE_BITS   = psvm_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = psvm_pkg::SINE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psvm_stream_if.sink    i_in,
    psvm_stream_if.source  o_out
);
    import psvm_pkg::*;

    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [SLOT_W-1:0] w_slot;
    logic              w_in_ready;
    t_in_item          w_in_item;
    t_out_item         w_out_item;
    logic              w_out_valid;

    assign w_in_item   = i_in.data;
    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_out_item;

    psvm_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_slot     (w_slot)
    );

    psvm_dp #(
        .VOICES       (VOICES),
        .SAMPLE_RATE  (SAMPLE_RATE),
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_slot      (w_slot),
        .o_sts       (w_sts),
        .i_item      (w_in_item),
        .o_item      (w_out_item),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready)
    );

endmodule

/* hdl/psvm_ctrl.sv */
module psvm_ctrl #(
    parameter int VOICES = psvm_pkg::VOICES_DEF,
    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  psvm_pkg::t_dp_sts i_sts,
    output psvm_pkg::t_dp_cmd o_cmd,
    output logic [SLOT_W-1:0] o_slot
);
    import psvm_pkg::*;

    localparam int LAST  = VOICES + PIPE_DRAIN - 1;
    localparam int CNT_W = $clog2(LAST + 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_slot     = r_cnt[SLOT_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.op == OP_NONE) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.issue = (r_cnt < CNT_W'(VOICES));
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(LAST)) begin
                        n_cnt = '0;
                        case (i_sts.op)
                            OP_ON:   n_state = ST_COMMIT;
                            OP_TICK: n_state = ST_EMIT;
                            default: n_state = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
        endcase
    end

endmodule

/* hdl/psvm_dp.sv */
module psvm_dp #(
    parameter int VOICES       = psvm_pkg::VOICES_DEF,
    parameter int SAMPLE_RATE  = psvm_pkg::SAMPLE_RATE_DEF,
    parameter int PHASE_BITS   = psvm_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = psvm_pkg::SINE_ENTRIES_DEF,
    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psvm_pkg::t_dp_cmd   i_cmd,
    input  logic [SLOT_W-1:0]   i_slot,
    output psvm_pkg::t_dp_sts   o_sts,
    input  psvm_pkg::t_in_item  i_item,
    output psvm_pkg::t_out_item o_item,
    output logic                o_out_valid,
    input  logic                i_out_ready
);
    import psvm_pkg::*;

    localparam int IDX_W  = $clog2(SINE_ENTRIES);
    localparam int PROD_W = PHASE_BITS + IDX_W;
    localparam logic [63:0] SR64 = 64'(SAMPLE_RATE);
    localparam logic [63:0] SE64 = 64'(SINE_ENTRIES);

    logic [PHASE_BITS-1:0]    w_inc      [NOTES];
    logic signed [SINE_W-1:0] w_sine_rom [SINE_ENTRIES];

    for (genvar g = 0; g < NOTES; g++) begin : g_inc
        localparam int OCT   = (g + NOTE_BIAS) / SEMIS - OCT_BIAS;
        localparam int K     = (g + NOTE_BIAS) % SEMIS;
        localparam int E     = PHASE_BITS - Q_FRAC + OCT;
        localparam int E_POS = (E >= 0) ? E : 0;
        localparam int E_NEG = (E < 0) ? -E : 0;
        localparam logic [63:0] NUM = REF_FREQ * SEMI_Q30[K];
        localparam logic [63:0] DIV = SR64 << E_NEG;
        localparam logic [63:0] INC = (E >= 0)
            ? ((NUM << E_POS) + SR64 / 64'd2) / SR64
            : (NUM + DIV / 64'd2) / DIV;
        assign w_inc[g] = INC[PHASE_BITS-1:0];
    end

    for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
        localparam logic [63:0] A0  = (64'(g) * 64'd2 * PI_Q30) / SE64;
        localparam logic        NEG = (A0 > PI_Q30);
        localparam logic [63:0] A1  = NEG ? (A0 - PI_Q30) : A0;
        localparam logic [63:0] A2  = (A1 > PI_Q30 / 64'd2) ? (PI_Q30 - A1) : A1;
        localparam logic [63:0] X2  = (A2 * A2) >> Q_FRAC;
        localparam logic [63:0] T1  = ONE_Q30 - ((X2 * ONE_Q30) >> Q_FRAC) / TAYLOR_DEN[0];
        localparam logic [63:0] T2  = ONE_Q30 - ((X2 * T1) >> Q_FRAC) / TAYLOR_DEN[1];
        localparam logic [63:0] T3  = ONE_Q30 - ((X2 * T2) >> Q_FRAC) / TAYLOR_DEN[2];
        localparam logic [63:0] T4  = ONE_Q30 - ((X2 * T3) >> Q_FRAC) / TAYLOR_DEN[3];
        localparam logic [63:0] T5  = ONE_Q30 - ((X2 * T4) >> Q_FRAC) / TAYLOR_DEN[4];
        localparam logic [63:0] T6  = ONE_Q30 - ((X2 * T5) >> Q_FRAC) / TAYLOR_DEN[5];
        localparam logic [63:0] S   = (A2 * T6) >> Q_FRAC;
        localparam logic [63:0] MAG = (S * 64'(AMP) + MAG_RND) >> Q_FRAC;
        assign w_sine_rom[g] = NEG ? -MAG[SINE_W-1:0] : MAG[SINE_W-1:0];
    end

    logic [NOTE_W-1:0]     r_note_mem  [VOICES];
    logic [PHASE_BITS-1:0] r_phase_mem [VOICES];
    logic [VOICES-1:0]     r_active;

    t_in_item              r_item;
    t_op                   w_op;

    logic                  r_s1_vld;
    logic [SLOT_W-1:0]     r_s1_slot;
    logic                  r_s1_act;
    logic [NOTE_W-1:0]     r_s1_note;
    logic [PHASE_BITS-1:0] r_s1_phase;

    logic                  r_s2_vld;
    logic [IDX_W-1:0]      r_s2_idx;
    logic                  r_s3_vld;
    logic signed [SINE_W-1:0] r_s3_sine;

    logic signed [SAMPLE_W-1:0] r_sum;
    logic                  r_match;
    logic                  r_free_found;
    logic [SLOT_W-1:0]     r_free_slot;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  w_s1_hit;
    logic                  w_tick_upd;
    logic                  w_off_clr;
    logic                  w_on_set;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_ph_we;
    logic [SLOT_W-1:0]     w_ph_addr;
    logic [PHASE_BITS-1:0] w_ph_wdata;

    always_comb begin
        unique case (r_item.cmd)
            CMD_NOTE_ON:  w_op = (r_item.velocity == '0) ? OP_OFF : OP_ON;
            CMD_NOTE_OFF: w_op = OP_OFF;
            CMD_TICK:     w_op = OP_TICK;
            default:      w_op = OP_NONE;
        endcase
    end

    assign o_sts.op       = w_op;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign w_s1_hit   = r_s1_vld && r_s1_act && (r_s1_note == r_item.note);
    assign w_tick_upd = r_s1_vld && r_s1_act && (w_op == OP_TICK);
    assign w_off_clr  = w_s1_hit && (w_op == OP_OFF);
    assign w_on_set   = i_cmd.commit && !r_match && r_free_found;
    assign w_prod     = PROD_W'(r_s1_phase) * PROD_W'(SINE_ENTRIES);

    always_comb begin
        w_ph_we    = w_tick_upd || w_on_set;
        w_ph_addr  = r_s1_slot;
        w_ph_wdata = r_s1_phase + w_inc[r_s1_note];
        if (w_on_set) begin
            w_ph_addr  = r_free_slot;
            w_ph_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ph_we) begin
            r_phase_mem[w_ph_addr] <= w_ph_wdata;
        end
        if (w_on_set) begin
            r_note_mem[r_free_slot] <= r_item.note;
        end
        r_s1_note  <= r_note_mem[i_slot];
        r_s1_phase <= r_phase_mem[i_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_off_clr) begin
                r_active[r_s1_slot] <= 1'b0;
            end else if (w_on_set) begin
                r_active[r_free_slot] <= 1'b1;
            end
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= w_tick_upd;
            r_s3_vld <= r_s2_vld;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        r_s1_slot <= i_slot;
        r_s1_act  <= r_active[i_slot];
        r_s2_idx  <= w_prod[PHASE_BITS +: IDX_W];
        r_s3_sine <= w_sine_rom[r_s2_idx];
        if (i_cmd.load) begin
            r_sum        <= '0;
            r_match      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (r_s3_vld) begin
                r_sum <= r_sum + SAMPLE_W'(r_s3_sine);
            end
            if (w_s1_hit) begin
                r_match <= 1'b1;
            end
            if (r_s1_vld && !r_s1_act && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_s1_slot;
            end
        end
        if (i_cmd.emit) begin
            r_out_item.sample <= r_sum;
        end
    end

    assign o_item      = r_out_item;
    assign o_out_valid = r_out_valid;

endmodule

/* tb/sv/polyphonic_sine_voice_mixer_tb.sv */
`timescale 1ns / 1ps

module polyphonic_sine_voice_mixer_tb;
    import psvm_pkg::*;

    localparam int VOICES       = VOICES_DEF;
    localparam int SAMPLE_RATE  = SAMPLE_RATE_DEF;
    localparam int PHASE_BITS   = PHASE_BITS_DEF;
    localparam int SINE_ENTRIES = SINE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 145;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [63:0] A4_HZ      = 64'd440;
    localparam logic [63:0] PI_FIX     = 64'd3373259426;
    localparam logic [63:0] ONE_FIX    = 64'd1073741824;
    localparam logic [63:0] SEMITONE_FIX [12] = '{
        64'd1073741824, 64'd1137589836, 64'd1205234447, 64'd1276901417,
        64'd1352829927, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };
    localparam logic [63:0] SERIES_DEN [6] = '{
        64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    typedef struct {
        t_in_item                   item;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] typed_sample;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psvm_stream_if #(.t_payload(t_in_item))  in_if ();
    psvm_stream_if #(.t_payload(t_out_item)) out_if ();

    polyphonic_sine_voice_mixer #(
        .VOICES      (VOICES),
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS),
        .SINE_ENTRIES(SINE_ENTRIES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    always #5 i_clk = ~i_clk;

    bit                    voice_on  [VOICES];
    logic [NOTE_W-1:0]     voice_key [VOICES];
    logic [PHASE_BITS-1:0] voice_acc [VOICES];
    logic [PHASE_BITS-1:0] step_of_note [NOTES];
    int                    sine_lut [SINE_ENTRIES];

    t_stim_row                  pending_rows [$];
    t_stim_row                  shown_row;
    logic signed [SAMPLE_W-1:0] expected_samples [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int items_taken    = 0;
    int samples_seen   = 0;
    int busy_drops     = 0;
    int cycle_count    = 0;

    function automatic logic [PHASE_BITS-1:0] note_step(input int n);
        int          oct;
        int          k;
        int          e;
        logic [63:0] num;
        logic [63:0] dv;
        logic [63:0] r;
        oct = (n + 3) / 12 - 6;
        k   = (n + 3) % 12;
        num = A4_HZ * SEMITONE_FIX[k];
        e   = PHASE_BITS - 30 + oct;
        if (e >= 0) begin
            r = ((num << e) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
        end else begin
            dv = 64'(SAMPLE_RATE) << (-e);
            r  = (num + dv / 2) / dv;
        end
        return PHASE_BITS'(r);
    endfunction

    function automatic int sine_value(input int i);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] iw;
        bit          neg;
        iw  = 64'(i);
        a   = (iw * 64'd2 * PI_FIX) / 64'(SINE_ENTRIES);
        neg = 1'b0;
        if (a > PI_FIX) begin
            a   = a - PI_FIX;
            neg = 1'b1;
        end
        if (a > PI_FIX / 2) begin
            a = PI_FIX - a;
        end
        x2 = (a * a) >> 30;
        t  = ONE_FIX;
        for (int j = 0; j < 6; j++) begin
            t = ONE_FIX - ((x2 * t) >> 30) / SERIES_DEN[j];
        end
        s   = (a * t) >> 30;
        mag = (s * 64'd2047 + 64'd4096) >> 30;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    function automatic void release_note(input logic [NOTE_W-1:0] n);
        for (int v = 0; v < VOICES; v++) begin
            if (voice_on[v] && voice_key[v] == n) begin
                voice_on[v] = 1'b0;
            end
        end
    endfunction

    function automatic void strike_note(input logic [NOTE_W-1:0] n);
        for (int v = 0; v < VOICES; v++) begin
            if (voice_on[v] && voice_key[v] == n) begin
                return;
            end
        end
        for (int v = 0; v < VOICES; v++) begin
            if (!voice_on[v]) begin
                voice_on[v]  = 1'b1;
                voice_key[v] = n;
                voice_acc[v] = '0;
                return;
            end
        end
        busy_drops++;
    endfunction

    function automatic void mix_item(input t_stim_row row);
        logic [SAMPLE_W-1:0] mix;
        logic [63:0]         idx;
        mix = '0;
        case (row.item.cmd)
            CMD_NOTE_ON: begin
                if (row.item.velocity == '0) begin
                    release_note(row.item.note);
                end else begin
                    strike_note(row.item.note);
                end
            end
            CMD_NOTE_OFF: begin
                release_note(row.item.note);
            end
            CMD_TICK: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (voice_on[v]) begin
                        idx = (64'(voice_acc[v]) * 64'(SINE_ENTRIES)) >> PHASE_BITS;
                        if (idx >= 64'(SINE_ENTRIES)) begin
                            idx = 64'(SINE_ENTRIES - 1);
                        end
                        mix          = mix + SAMPLE_W'(sine_lut[idx]);
                        voice_acc[v] = voice_acc[v] + step_of_note[voice_key[v]];
                    end
                end
                expected_samples.push_back(row.typed ? row.typed_sample : $signed(mix));
            end
            default: begin
            end
        endcase
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note,
                           input logic [VEL_W-1:0] vel, input bit typed,
                           input logic signed [SAMPLE_W-1:0] typed_sample);
        t_stim_row row;
        row.item.cmd      = cmd;
        row.item.note     = note;
        row.item.velocity = vel;
        row.typed         = typed;
        row.typed_sample  = typed_sample;
        pending_rows.push_back(row);
    endtask

    task automatic queue_random(input int count, input int on_w, input int off_w);
        int                made;
        int                r;
        t_stim_row         row;
        logic [NOTE_W-1:0] live [$];
        made = 0;
        while (made < count) begin
            while (pending_rows.size() != 0) @(negedge i_clk);
            live.delete();
            for (int v = 0; v < VOICES; v++) begin
                if (voice_on[v]) begin
                    live.push_back(voice_key[v]);
                end
            end
            row.typed         = 1'b0;
            row.typed_sample  = '0;
            row.item.note     = NOTE_W'($urandom_range(NOTES - 1));
            row.item.velocity = VEL_W'($urandom_range(127));
            r = $urandom_range(99);
            if (r < 38) begin
                row.item.cmd = CMD_TICK;
            end else if (r < 38 + on_w) begin
                row.item.cmd      = CMD_NOTE_ON;
                row.item.velocity = VEL_W'($urandom_range(127, 1));
                if (live.size() != 0 && $urandom_range(3) == 0) begin
                    row.item.note = live[$urandom_range(live.size() - 1)];
                end
            end else if (r < 38 + on_w + off_w) begin
                if ($urandom_range(1) == 1) begin
                    row.item.cmd = CMD_NOTE_OFF;
                end else begin
                    row.item.cmd      = CMD_NOTE_ON;
                    row.item.velocity = '0;
                end
                if (live.size() != 0 && $urandom_range(4) != 0) begin
                    row.item.note = live[$urandom_range(live.size() - 1)];
                end
            end else begin
                row.item.cmd = CMD_UNUSED;
            end
            if (row.item.cmd != CMD_UNUSED) begin
                made++;
            end
            pending_rows.push_back(row);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                mix_item(shown_row);
                items_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    shown_row = pending_rows.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data  <= shown_row.item;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                $error("sample: expected none, actual %0d", out_if.data.sample);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (out_if.data.sample !== want) begin
                    $error("sample: expected %0d, actual %0d", want, out_if.data.sample);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding",
                     cycle_count, expected_samples.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        for (int v = 0; v < VOICES; v++) begin
            voice_on[v]  = 1'b0;
            voice_key[v] = '0;
            voice_acc[v] = '0;
        end
        for (int n = 0; n < NOTES; n++) begin
            step_of_note[n] = note_step(n);
        end
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            sine_lut[i] = sine_value(i);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // silence after reset, then fresh voices start at phase zero
        add_row(CMD_TICK, 7'd0, 7'd0, 1'b1, 16'sd0);
        add_row(CMD_NOTE_ON, 7'd0, 7'd127, 1'b0, '0);
        add_row(CMD_NOTE_ON, 7'd127, 7'd1, 1'b0, '0);
        add_row(CMD_TICK, 7'd127, 7'd127, 1'b1, 16'sd0);
        add_row(CMD_TICK, 7'd0, 7'd0, 1'b0, '0);
        add_row(CMD_NOTE_ON, 7'd0, 7'd64, 1'b0, '0);
        add_row(CMD_NOTE_OFF, 7'd64, 7'd0, 1'b0, '0);
        add_row(CMD_NOTE_ON, 7'd127, 7'd0, 1'b0, '0);
        add_row(CMD_UNUSED, 7'd127, 7'd127, 1'b0, '0);
        add_row(CMD_TICK, 7'd0, 7'd0, 1'b0, '0);
        // fill every voice, then overflow
        for (int i = 1; i < VOICES; i++) begin
            add_row(CMD_NOTE_ON, NOTE_W'(i * 8 + 3), VEL_W'(i * 8 + 7), 1'b0, '0);
        end
        add_row(CMD_NOTE_ON, 7'd100, 7'd33, 1'b0, '0);
        add_row(CMD_TICK, 7'd0, 7'd0, 1'b0, '0);

        queue_random(RANDOM_ITEMS, 37, 18);
        send_idle_pct  = 47;
        recv_stall_pct = 0;
        queue_random(RANDOM_ITEMS, 27, 28);
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        queue_random(RANDOM_ITEMS, 44, 11);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        queue_random(RANDOM_ITEMS, 32, 23);

        while (pending_rows.size() != 0 || in_if.valid) @(negedge i_clk);
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (VOICES + 8) @(negedge i_clk);

        $display("Covered %0d items and %0d samples over four idle/stall mixes;",
                 items_taken, samples_seen);
        $display("%0d note-ons arrived with every voice busy.", busy_drops);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/psvm_pkg.sv
hdl/psvm_stream_if.sv
hdl/psvm_ctrl.sv
hdl/psvm_dp.sv
hdl/polyphonic_sine_voice_mixer.sv
tb/sv/polyphonic_sine_voice_mixer_tb.sv
